### rtl/sppq_pkg.sv
// shared types and codes for the sorted priority queue
package sppq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RANK_W  = 16;

	// result codes
	typedef enum logic [1:0] {
		STATUS_INSERTED  = 2'd0,
		STATUS_REMOVED   = 2'd1,
		STATUS_UNDERFLOW = 2'd2,
		STATUS_OVERFLOW  = 2'd3
	} status_t;

	// request codes
	typedef enum logic {
		ACTION_INSERT = 1'b0,
		ACTION_REMOVE = 1'b1
	} action_t;

	// contents and insert decision of one cell as seen by its neighbors
	typedef struct packed {
		logic                     valid;
		logic                     keep;
		logic        [VALUE_W-1:0] value;
		logic signed [RANK_W-1:0]  rank;
	} cell_t;

	// operation broadcast to every cell, already gated by full and empty
	typedef struct packed {
		logic                     insert;
		logic                     remove;
		logic        [VALUE_W-1:0] value;
		logic signed [RANK_W-1:0]  rank;
	} op_t;

endpackage

### rtl/sppq_cell.sv
// one slot of the sorted queue: holds an entry and trades it with its neighbors
module sppq_cell
	import sppq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  cell_t left,
	input  cell_t right,
	output cell_t own
);

	logic                      valid_q;
	logic         [VALUE_W-1:0] value_q;
	logic signed  [RANK_W-1:0]  rank_q;
	logic                      keep;

	// an entry of higher or equal priority stays put on insert
	assign keep = valid_q && (rank_q >= op.rank);

	assign own.valid = valid_q;
	assign own.keep  = keep;
	assign own.value = value_q;
	assign own.rank  = rank_q;

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.remove) begin
			valid_q <= right.valid;
		end else if (op.insert && !keep) begin
			valid_q <= left.keep ? 1'b1 : left.valid;
		end
	end

	// entry payload: shift toward the head on remove, away on insert
	always_ff @(posedge clk) begin
		if (op.remove) begin
			value_q <= right.value;
			rank_q  <= right.rank;
		end else if (op.insert && !keep) begin
			if (left.keep) begin
				value_q <= op.value;
				rank_q  <= op.rank;
			end else begin
				value_q <= left.value;
				rank_q  <= left.rank;
			end
		end
	end

endmodule

### rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: cell row, request decode and result register
// The queue holds up to DEPTH entries in a row of cells kept sorted by descending
// priority, equal priorities in arrival order. Every input word (tuser 0 insert,
// 1 remove) yields exactly one result word, so a new word is accepted every cycle
// unless the result register still holds an untaken word. The whole row shifts at
// once when a word is taken, one neighbor step per cell; the head cell feeds the
// remove result. An insert into a full queue reports overflow, a remove on an
// empty queue reports underflow; both leave the contents unchanged.
module sorted_priority_queue
	import sppq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // item_value [31:0], item_rank [47:32]
	input  logic        s_tuser,   // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_value [31:0], out_rank [47:32]
	output logic [1:0]  m_tuser    // status [1:0]
);

	cell_t   cells [DEPTH];
	cell_t   lefts [DEPTH];
	cell_t   rights[DEPTH];
	op_t     op;
	logic    take;
	logic    is_remove;
	logic    full;
	logic    empty;
	status_t status;
	logic    m_tvalid_q;
	logic [47:0] m_tdata_q;
	status_t m_tuser_q;

	assign s_tready  = !m_tvalid_q || m_tready;
	assign take      = s_tvalid && s_tready;
	assign is_remove = (action_t'(s_tuser) == ACTION_REMOVE);
	assign full      = cells[DEPTH-1].valid;
	assign empty     = !cells[0].valid;

	// request decode, gated so a dropped request leaves the row alone
	always_comb begin
		op.insert = take && !is_remove && !full;
		op.remove = take && is_remove && !empty;
		op.value  = s_tdata[VALUE_W-1:0];
		op.rank   = s_tdata[VALUE_W+RANK_W-1:VALUE_W];
		if (is_remove) begin
			status = empty ? STATUS_UNDERFLOW : STATUS_REMOVED;
		end else begin
			status = full ? STATUS_OVERFLOW : STATUS_INSERTED;
		end
	end

	// row of cells with head on the left
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign lefts[i] = '{valid: 1'b1, keep: 1'b1, value: '0, rank: '0};
		end else begin : g_mid
			assign lefts[i] = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rights[i] = '{valid: 1'b0, keep: 1'b0, value: '0, rank: '0};
		end else begin : g_body
			assign rights[i] = cells[i+1];
		end
		sppq_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.op    (op),
			.left  (lefts[i]),
			.right (rights[i]),
			.own   (cells[i])
		);
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (take) begin
			m_tuser_q <= status;
			if (op.remove) begin
				m_tdata_q <= {cells[0].rank, cells[0].value};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
